/* hw/rtl/afrc_pkg.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// afrc_pkg
// Shared types and constants of the audio buffer rate-control monitor.
// -----------------------------------------------------------------------------
package afrc_pkg;

   localparam int LEVEL_W    = 21;
   localparam int RATIO_W    = 32;
   localparam int DELTA_W    = 16;
   localparam int CNT_W      = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int WIDE_W     = 64;
   localparam int DIVR_W     = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_BUFFER_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_RATIO  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_DELTA  = 2'd2;

   localparam logic [LEVEL_W-1:0] RST_BUFFER_SIZE = 21'd4096;
   localparam logic [RATIO_W-1:0] RST_BASE_RATIO  = 32'd65536;
   localparam logic [DELTA_W-1:0] RST_RATE_DELTA  = 16'd328;

   localparam logic [31:0] MIN_ENTRIES = 32'd3;

   localparam logic OP_MEASURE = 1'b0;
   localparam logic OP_REPORT  = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_M_PREP,
      ST_M_DIV,
      ST_M_DIV_WAIT,
      ST_M_MUL_LO,
      ST_M_MUL_HI,
      ST_M_SAT,
      ST_R_SUM,
      ST_R_SUM_WAIT,
      ST_R_MEAN_DIV,
      ST_R_MEAN_WAIT,
      ST_R_SQ,
      ST_R_SQ_WAIT,
      ST_R_VAR_DIV,
      ST_R_VAR_WAIT,
      ST_R_SQRT,
      ST_R_SQRT_WAIT,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      OUT_RATIO,
      OUT_ZERO,
      OUT_REPORT
   } out_sel_type;

   typedef enum logic [1:0] {
      DIV_RATIO,
      DIV_MEAN,
      DIV_VAR
   } div_sel_type;

   typedef struct packed {
      logic        meas_take;
      logic        rpt_take;
      logic        prep;
      logic        div_start;
      div_sel_type div_sel;
      logic        mul_lo;
      logic        mul_hi;
      logic        sat;
      logic        walk_start;
      logic        walk_sq;
      logic        mean_load;
      logic        sqrt_start;
      logic        load_out;
      out_sel_type out_sel;
   } cmd_type;

   typedef struct packed {
      logic half_zero;
      logic few;
      logic div_done;
      logic walk_busy;
      logic sqrt_done;
   } sts_type;

endpackage

/* hw/rtl/afrc_if.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// afrc_if
// Valid/ready channels for request and response beats.
// -----------------------------------------------------------------------------
interface afrc_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [20:0] free_level;

   modport source (output valid, output op, output free_level, input ready);
   modport sink   (input valid, input op, input free_level, output ready);
endinterface

interface afrc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] new_ratio;
   logic        report_valid;
   logic [20:0] mean_free;
   logic [20:0] spread;
   logic [10:0] near_underrun_count;
   logic [10:0] near_block_count;
   logic [10:0] used_entries;

   modport source (output valid, output new_ratio, output report_valid, output mean_free,
                   output spread, output near_underrun_count, output near_block_count,
                   output used_entries, input ready);
   modport sink   (input valid, input new_ratio, input report_valid, input mean_free,
                   input spread, input near_underrun_count, input near_block_count,
                   input used_entries, output ready);
endinterface

/* hw/rtl/audio_fifo_rate_control_monitor_top.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// audio_fifo_rate_control_monitor_top
// Audio output buffer rate-control monitor: ratio steering and level statistics.
// -----------------------------------------------------------------------------
// The block takes one request beat at a time. A measure beat runs a serial divider that
// forms the ratio adjustment, unless half the buffer size is zero. A report beat makes
// two walks over the history RAM at one entry per cycle, two passes of the same divider
// and a square root; with fewer than three entries it skips them and answers with an
// all-zero response. A finished response waits in its output register; the next
// request is taken once it has been loaded. The history RAM needs no clearing after reset.
module audio_fifo_rate_control_monitor_top
   import afrc_pkg::*;
#(
   parameter int HISTORY_DEPTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   afrc_req_if.sink              req,
   afrc_rsp_if.source            rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   afrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_op    (req.op),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   afrc_dp #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .sts                     (sts),
      .req_free_level          (req.free_level),
      .csr_we                  (csr_we),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata),
      .out_new_ratio           (rsp.new_ratio),
      .out_report_valid        (rsp.report_valid),
      .out_mean_free           (rsp.mean_free),
      .out_spread              (rsp.spread),
      .out_near_underrun_count (rsp.near_underrun_count),
      .out_near_block_count    (rsp.near_block_count),
      .out_used_entries        (rsp.used_entries)
   );

endmodule

/* hw/rtl/afrc_ram.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// afrc_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module afrc_ram #(
   parameter int WIDTH = 21,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

/* hw/rtl/afrc_div.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// afrc_div
// Restoring divider, one quotient bit per cycle.
// -----------------------------------------------------------------------------
module afrc_div
   import afrc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WIDE_W-1:0] dividend,
   input  logic [DIVR_W-1:0] divisor,
   output logic [WIDE_W-1:0] quotient,
   output logic              done
);

   logic              busy_ff;
   logic              done_ff;
   logic [6:0]        cnt_ff;
   logic [WIDE_W-1:0] dq_ff;
   logic [DIVR_W-1:0] rem_ff;
   logic [DIVR_W-1:0] dvs_ff;
   logic [DIVR_W:0]   rem2;
   logic              ge;

   assign rem2 = {rem_ff, dq_ff[WIDE_W-1]};
   assign ge   = rem2 >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 7'(WIDE_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // The dividend shifts out at the top while quotient bits enter at the bottom.
   always_ff @(posedge clock) begin
      if (start) begin
         dq_ff  <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? DIVR_W'(rem2 - {1'b0, dvs_ff}) : rem2[DIVR_W-1:0];
         dq_ff  <= {dq_ff[WIDE_W-2:0], ge};
      end
   end

   assign quotient = dq_ff;
   assign done     = done_ff;

endmodule

/* hw/rtl/afrc_sqrt.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// afrc_sqrt
// Integer square root, two radicand bits per cycle.
// -----------------------------------------------------------------------------
module afrc_sqrt
   import afrc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WIDE_W-1:0] radicand,
   output logic [WIDE_W-1:0] root,
   output logic              done
);

   logic              busy_ff;
   logic              done_ff;
   logic [5:0]        cnt_ff;
   logic [WIDE_W-1:0] x_ff;
   logic [WIDE_W-1:0] res_ff;
   logic [WIDE_W-1:0] bit_ff;
   logic [WIDE_W-1:0] trial;

   assign trial = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'(WIDE_W / 2);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff   <= radicand;
         res_ff <= '0;
         bit_ff <= {2'b01, {(WIDE_W-2){1'b0}}};
      end else if (busy_ff) begin
         if (x_ff >= trial) begin
            x_ff   <= x_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign root = res_ff;
   assign done = done_ff;

endmodule

/* hw/rtl/afrc_ctrl.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// afrc_ctrl
// Sequencer that steps the datapath through measure and report beats.
// -----------------------------------------------------------------------------
module afrc_ctrl
   import afrc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_op,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type   state_ff, state_in;
   out_sel_type sel_ff, sel_in;
   logic        valid_ff, valid_in;
   logic        accept;
   logic        slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_MEASURE) begin
                  state_in = ST_M_PREP;
               end else if (sts.few) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_R_SUM;
               end
            end
         end
         ST_M_PREP:      state_in = sts.half_zero ? ST_DONE : ST_M_DIV;
         ST_M_DIV:       state_in = ST_M_DIV_WAIT;
         ST_M_DIV_WAIT:  if (sts.div_done) state_in = ST_M_MUL_LO;
         ST_M_MUL_LO:    state_in = ST_M_MUL_HI;
         ST_M_MUL_HI:    state_in = ST_M_SAT;
         ST_M_SAT:       state_in = ST_DONE;
         ST_R_SUM:       state_in = ST_R_SUM_WAIT;
         ST_R_SUM_WAIT:  if (!sts.walk_busy) state_in = ST_R_MEAN_DIV;
         ST_R_MEAN_DIV:  state_in = ST_R_MEAN_WAIT;
         ST_R_MEAN_WAIT: if (sts.div_done) state_in = ST_R_SQ;
         ST_R_SQ:        state_in = ST_R_SQ_WAIT;
         ST_R_SQ_WAIT:   if (!sts.walk_busy) state_in = ST_R_VAR_DIV;
         ST_R_VAR_DIV:   state_in = ST_R_VAR_WAIT;
         ST_R_VAR_WAIT:  if (sts.div_done) state_in = ST_R_SQRT;
         ST_R_SQRT:      state_in = ST_R_SQRT_WAIT;
         ST_R_SQRT_WAIT: if (sts.sqrt_done) state_in = ST_DONE;
         ST_DONE:        if (slot_free) state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.div_sel = DIV_RATIO;
      cmd.out_sel = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.meas_take = accept && (req_op == OP_MEASURE);
            cmd.rpt_take  = accept && (req_op == OP_REPORT);
         end
         ST_M_PREP:   cmd.prep = 1'b1;
         ST_M_DIV:    cmd.div_start = 1'b1;
         ST_M_MUL_LO: cmd.mul_lo = 1'b1;
         ST_M_MUL_HI: cmd.mul_hi = 1'b1;
         ST_M_SAT:    cmd.sat = 1'b1;
         ST_R_SUM:    cmd.walk_start = 1'b1;
         ST_R_MEAN_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_MEAN;
         end
         ST_R_SQ: begin
            cmd.mean_load  = 1'b1;
            cmd.walk_start = 1'b1;
            cmd.walk_sq    = 1'b1;
         end
         ST_R_VAR_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_VAR;
         end
         ST_R_SQRT: cmd.sqrt_start = 1'b1;
         ST_DONE:   cmd.load_out = slot_free;
         default:   cmd = '0;
      endcase
   end

   always_comb begin
      sel_in = sel_ff;
      if (accept) begin
         if (req_op == OP_MEASURE) begin
            sel_in = OUT_RATIO;
         end else begin
            sel_in = sts.few ? OUT_ZERO : OUT_REPORT;
         end
      end
      valid_in = valid_ff;
      if (cmd.load_out) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= OUT_ZERO;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         valid_ff <= valid_in;
      end
   end

endmodule

/* hw/rtl/afrc_dp.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// afrc_dp
// Datapath: registers, history RAM, ratio arithmetic and statistics walks.
// -----------------------------------------------------------------------------
module afrc_dp
   import afrc_pkg::*;
#(
   parameter int HISTORY_DEPTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output sts_type               sts,
   input  logic [LEVEL_W-1:0]    req_free_level,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic [RATIO_W-1:0]    out_new_ratio,
   output logic                  out_report_valid,
   output logic [LEVEL_W-1:0]    out_mean_free,
   output logic [LEVEL_W-1:0]    out_spread,
   output logic [CNT_W-1:0]      out_near_underrun_count,
   output logic [CNT_W-1:0]      out_near_block_count,
   output logic [CNT_W-1:0]      out_used_entries
);

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int NW = AW + 1;

   logic [LEVEL_W-1:0] size_ff;
   logic [RATIO_W-1:0] base_ff;
   logic [DELTA_W-1:0] delta_ff;
   logic [31:0]        count_ff;
   logic [AW-1:0]      wptr_ff;
   logic [NW-1:0]      n_ff;
   logic [NW-1:0]      n_cur;
   logic [LEVEL_W-1:0] level_ff;

   logic [LEVEL_W-2:0] half;
   logic               up_now;
   logic [LEVEL_W-1:0] mag;
   logic               up_ff;
   logic [WIDE_W-1:0]  num_ff;
   logic [RATIO_W-1:0] ratio_ff;

   logic              div_start;
   logic [WIDE_W-1:0] div_dividend;
   logic [DIVR_W-1:0] div_divisor;
   logic [WIDE_W-1:0] div_q;
   logic              div_done;

   logic [WIDE_W-1:0]  mul_ff;
   logic [RATIO_W-1:0] term_ff;
   logic [RATIO_W-1:0] mul_b;
   logic [WIDE_W:0]    sum_term;
   logic [WIDE_W+1:0]  up_sum;

   logic [AW-1:0]        addr_ff;
   logic                 issue_ff;
   logic                 v1_ff, v2_ff, v3_ff;
   logic                 sqmode_ff;
   logic [LEVEL_W-1:0]   rdata;
   logic [LEVEL_W-1:0]   d_ff;
   logic [2*LEVEL_W-1:0] sq_ff;
   logic [WIDE_W-1:0]    acc_ff;
   logic [CNT_W-1:0]     under_ff, block_ff;
   logic [LEVEL_W-1:0]   mean_ff;
   logic [LEVEL_W+1:0]   lo_mark;
   logic [LEVEL_W-1:0]   hi_mark;
   logic                 last;

   logic              sqrt_done;
   logic [WIDE_W-1:0] sqrt_root;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= RST_BUFFER_SIZE;
         base_ff  <= RST_BASE_RATIO;
         delta_ff <= RST_RATE_DELTA;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BUFFER_SIZE: size_ff  <= csr_wdata[LEVEL_W-1:0];
            CSR_BASE_RATIO:  base_ff  <= csr_wdata[RATIO_W-1:0];
            CSR_RATE_DELTA:  delta_ff <= csr_wdata[DELTA_W-1:0];
            default: ;
         endcase
      end
   end

   // Measurement count and ring write pointer; the pointer follows count modulo depth,
   // including the wrap of the 32-bit count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wptr_ff  <= '0;
      end else if (cmd.meas_take) begin
         count_ff <= count_ff + 32'd1;
         if (count_ff == 32'hFFFF_FFFF || wptr_ff == AW'(HISTORY_DEPTH - 1)) begin
            wptr_ff <= '0;
         end else begin
            wptr_ff <= wptr_ff + AW'(1);
         end
      end
   end

   assign n_cur = (count_ff >= 32'(HISTORY_DEPTH)) ? NW'(HISTORY_DEPTH) : count_ff[NW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.meas_take) begin
         level_ff <= req_free_level;
      end
      if (cmd.rpt_take) begin
         n_ff <= n_cur;
      end
   end

   afrc_ram #(.WIDTH(LEVEL_W), .DEPTH(HISTORY_DEPTH)) u_ram (
      .clock (clock),
      .we    (cmd.meas_take),
      .waddr (wptr_ff),
      .wdata (req_free_level),
      .raddr (addr_ff),
      .rdata (rdata)
   );

   // Ratio path.
   assign half   = size_ff[LEVEL_W-1:1];
   assign up_now = level_ff >= {1'b0, half};
   assign mag    = up_now ? level_ff - {1'b0, half} : {1'b0, half} - level_ff;

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         up_ff    <= up_now;
         num_ff   <= WIDE_W'(delta_ff * mag) << 16;
         ratio_ff <= base_ff;
      end else if (cmd.sat) begin
         if (up_ff) begin
            ratio_ff <= (up_sum[WIDE_W+1:RATIO_W] != '0) ? '1 : up_sum[RATIO_W-1:0];
         end else begin
            ratio_ff <= (sum_term >= {33'b0, base_ff}) ? '0 :
                        RATIO_W'({33'b0, base_ff} - sum_term);
         end
      end
   end

   assign mul_b = cmd.mul_hi ? div_q[WIDE_W-1:RATIO_W] : div_q[RATIO_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.mul_lo || cmd.mul_hi) begin
         mul_ff <= base_ff * mul_b;
      end
      if (cmd.mul_hi) begin
         term_ff <= mul_ff[WIDE_W-1:RATIO_W];
      end
   end

   assign sum_term = {33'b0, term_ff} + {1'b0, mul_ff};
   assign up_sum   = {34'b0, base_ff} + {1'b0, sum_term};

   // Shared divider.
   always_comb begin
      div_start = cmd.div_start;
      case (cmd.div_sel)
         DIV_RATIO: begin
            div_dividend = num_ff;
            div_divisor  = DIVR_W'(half);
         end
         DIV_MEAN: begin
            div_dividend = acc_ff;
            div_divisor  = DIVR_W'(n_ff - NW'(1));
         end
         DIV_VAR: begin
            div_dividend = acc_ff;
            div_divisor  = DIVR_W'(n_ff - NW'(2));
         end
         default: begin
            div_dividend = acc_ff;
            div_divisor  = DIVR_W'(n_ff);
         end
      endcase
   end

   afrc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_q),
      .done     (div_done)
   );

   // History walk over entries 1 .. n-1. The first pass sums and counts, the second
   // accumulates squared deviations from the mean.
   assign last    = {1'b0, addr_ff} == (n_ff - NW'(1));
   assign lo_mark = ({2'b0, size_ff} * 23'd3) >> 2;
   assign hi_mark = size_ff >> 2;

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
      end else begin
         if (cmd.walk_start) begin
            issue_ff <= 1'b1;
         end else if (issue_ff && last) begin
            issue_ff <= 1'b0;
         end
         v1_ff <= issue_ff;
         v2_ff <= v1_ff && sqmode_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_start) begin
         addr_ff   <= AW'(1);
         sqmode_ff <= cmd.walk_sq;
         acc_ff    <= '0;
         if (!cmd.walk_sq) begin
            under_ff <= '0;
            block_ff <= '0;
         end
      end else begin
         if (issue_ff) begin
            addr_ff <= addr_ff + AW'(1);
         end
         if (v1_ff && !sqmode_ff) begin
            acc_ff <= acc_ff + WIDE_W'(rdata);
            if ({2'b0, rdata} >= lo_mark) begin
               under_ff <= under_ff + CNT_W'(1);
            end else if (rdata <= hi_mark) begin
               block_ff <= block_ff + CNT_W'(1);
            end
         end
         if (v3_ff) begin
            acc_ff <= acc_ff + WIDE_W'(sq_ff);
         end
      end
      if (v1_ff && sqmode_ff) begin
         d_ff <= (rdata > mean_ff) ? rdata - mean_ff : mean_ff - rdata;
      end
      if (v2_ff) begin
         sq_ff <= d_ff * d_ff;
      end
      if (cmd.mean_load) begin
         mean_ff <= div_q[LEVEL_W-1:0];
      end
   end

   afrc_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_start),
      .radicand (div_q),
      .root     (sqrt_root),
      .done     (sqrt_done)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_new_ratio           <= '0;
         out_report_valid        <= 1'b0;
         out_mean_free           <= '0;
         out_spread              <= '0;
         out_near_underrun_count <= '0;
         out_near_block_count    <= '0;
         out_used_entries        <= '0;
         case (cmd.out_sel)
            OUT_RATIO: out_new_ratio <= ratio_ff;
            OUT_REPORT: begin
               out_report_valid        <= 1'b1;
               out_mean_free           <= mean_ff;
               out_spread              <= sqrt_root[LEVEL_W-1:0];
               out_near_underrun_count <= under_ff;
               out_near_block_count    <= block_ff;
               out_used_entries        <= CNT_W'(n_ff - NW'(1));
            end
            default: ;
         endcase
      end
   end

   assign sts.half_zero = (half == '0);
   assign sts.few       = count_ff < MIN_ENTRIES;
   assign sts.div_done  = div_done;
   assign sts.walk_busy = issue_ff || v1_ff || v2_ff || v3_ff;
   assign sts.sqrt_done = sqrt_done;

endmodule

/* hw/rtl/afrc_chk.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// afrc_chk
// Port-level checks of the rate-control monitor, bound to the top level.
// -----------------------------------------------------------------------------
module afrc_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_new_ratio,
   input logic        rsp_report_valid,
   input logic [20:0] rsp_mean_free,
   input logic [20:0] rsp_spread,
   input logic [10:0] rsp_near_underrun_count,
   input logic [10:0] rsp_near_block_count,
   input logic [10:0] rsp_used_entries
);

   // A waiting response beat keeps its ratio, report flag and entry count.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_new_ratio)
         && $stable(rsp_report_valid) && $stable(rsp_used_entries))
      else $error("response changed while stalled");

   // One request at a time: no request is taken in the cycle after one was.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_report_valid |-> rsp_mean_free == '0 && rsp_spread == '0
         && rsp_near_underrun_count == '0 && rsp_near_block_count == '0
         && rsp_used_entries == '0)
      else $error("statistics on a beat without a valid report");

   a_report_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_report_valid |-> rsp_new_ratio == '0 && rsp_used_entries >= 11'd2
         && ({1'b0, rsp_near_underrun_count} + {1'b0, rsp_near_block_count})
            <= {1'b0, rsp_used_entries})
      else $error("malformed report beat");

endmodule

bind audio_fifo_rate_control_monitor_top afrc_chk u_afrc_chk (
   .clock                   (clock),
   .reset                   (reset),
   .req_valid               (req.valid),
   .req_ready               (req.ready),
   .rsp_valid               (rsp.valid),
   .rsp_ready               (rsp.ready),
   .rsp_new_ratio           (rsp.new_ratio),
   .rsp_report_valid        (rsp.report_valid),
   .rsp_mean_free           (rsp.mean_free),
   .rsp_spread              (rsp.spread),
   .rsp_near_underrun_count (rsp.near_underrun_count),
   .rsp_near_block_count    (rsp.near_block_count),
   .rsp_used_entries        (rsp.used_entries)
);

/* tb/sv/tb_audio_fifo_rate_control_monitor_top.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_audio_fifo_rate_control_monitor_top
// Self-checking bench for the audio buffer rate-control monitor. A driver sends
// measure and report beats in random bursts, and a monitor compares every
// response with a built-in predictor of the ratio and history statistics.
// Several register settings are exercised, the extremes among them.
// -----------------------------------------------------------------------------
module tb_audio_fifo_rate_control_monitor_top;
   import afrc_pkg::*;

   localparam int HIST       = 1024;
   localparam int IDLE_LIMIT = 40000;

   typedef struct {
      logic                op;
      logic [LEVEL_W-1:0]  level;
   } level_beat_type;

   typedef struct {
      logic [RATIO_W-1:0] ratio;
      logic               rpt_ok;
      logic [LEVEL_W-1:0] mean;
      logic [LEVEL_W-1:0] dev;
      logic [CNT_W-1:0]   under;
      logic [CNT_W-1:0]   block;
      logic [CNT_W-1:0]   used;
   } monitor_rsp_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   afrc_req_if req_if ();
   afrc_rsp_if rsp_if ();

   audio_fifo_rate_control_monitor_top #(.HISTORY_DEPTH(HIST)) uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor state.
   logic [LEVEL_W-1:0] size_reg;
   logic [RATIO_W-1:0] base_reg;
   logic [DELTA_W-1:0] delta_reg;
   logic [LEVEL_W-1:0] level_hist [HIST];
   logic [31:0]        meas_total;

   level_beat_type  pending_beats [$];
   monitor_rsp_type expected_rsp [$];
   int              mismatches = 0;
   bit              drain_hold;
   int              idle_cycles;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned root;
      longint unsigned probe;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > x) probe = probe >> 2;
      while (probe != 0) begin
         if (x >= root + probe) begin
            x    = x - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   function automatic logic [RATIO_W-1:0] steered_ratio(logic [LEVEL_W-1:0] level);
      longint unsigned half;
      longint unsigned mag;
      longint unsigned adj;
      longint unsigned term;
      longint unsigned sum;
      half = size_reg / 2;
      if (half == 0) return base_reg;
      mag  = (level >= half) ? level - half : half - level;
      adj  = (longint'(delta_reg) * mag * 65536) / half;
      term = longint'(base_reg) * (adj >> 32) + ((longint'(base_reg) * adj[31:0]) >> 32);
      if (level >= half) begin
         sum = longint'(base_reg) + term;
         return (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
      end
      return (term >= base_reg) ? '0 : base_reg - term[31:0];
   endfunction

   function automatic monitor_rsp_type history_stats();
      monitor_rsp_type r;
      int unsigned n;
      longint unsigned acc;
      longint unsigned sq;
      longint unsigned d;
      longint unsigned avg;
      longint unsigned hi_mark;
      longint unsigned lo_mark;
      r = '{default: '0};
      n = (meas_total < HIST) ? meas_total : HIST;
      if (n < 3) return r;
      acc = 0;
      sq  = 0;
      for (int i = 1; i < n; i++) acc += level_hist[i];
      avg = acc / (n - 1);
      for (int i = 1; i < n; i++) begin
         d  = (level_hist[i] > avg) ? level_hist[i] - avg : avg - level_hist[i];
         sq += d * d;
      end
      hi_mark = (longint'(size_reg) * 3) / 4;
      lo_mark = size_reg / 4;
      for (int i = 1; i < n; i++) begin
         if (level_hist[i] >= hi_mark) r.under++;
         else if (level_hist[i] <= lo_mark) r.block++;
      end
      r.rpt_ok = 1'b1;
      r.mean   = avg[LEVEL_W-1:0];
      r.dev    = LEVEL_W'(int_sqrt(sq / (n - 2)));
      r.used   = CNT_W'(n - 1);
      return r;
   endfunction

   task automatic predict_beat(logic op, logic [LEVEL_W-1:0] level);
      monitor_rsp_type r;
      r = '{default: '0};
      if (op == OP_MEASURE) begin
         level_hist[meas_total % HIST] = level;
         meas_total = meas_total + 1;
         r.ratio = steered_ratio(level);
      end else begin
         r = history_stats();
      end
      expected_rsp.push_back(r);
   endtask

   // Driver: bursts of random length separated by random gaps.
   int burst_left;
   int gap_left;
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid      <= 1'b0;
         req_if.op         <= OP_MEASURE;
         req_if.free_level <= '0;
         burst_left = 4;
         gap_left   = 0;
      end else begin
         if (req_if.valid && req_if.ready) predict_beat(req_if.op, req_if.free_level);
         if (!(req_if.valid && !req_if.ready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (pending_beats.size() != 0 && !drain_hold) begin
               level_beat_type b;
               b = pending_beats.pop_front();
               req_if.valid      <= 1'b1;
               req_if.op         <= b.op;
               req_if.free_level <= b.level;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 20);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stall density changes from window to window, sometimes none.
   int stall_left;
   int stall_pct;
   int window;
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
         stall_pct  = 0;
         window     = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_rsp.size() == 0) begin
               $error("response beat with nothing expected");
               mismatches++;
            end else begin
               monitor_rsp_type e;
               e = expected_rsp.pop_front();
               if (rsp_if.new_ratio !== e.ratio) begin
                  $error("new_ratio exp %0h got %0h", e.ratio, rsp_if.new_ratio);
                  mismatches++;
               end
               if (rsp_if.report_valid !== e.rpt_ok) begin
                  $error("report_valid exp %0d got %0d", e.rpt_ok, rsp_if.report_valid);
                  mismatches++;
               end
               if (rsp_if.mean_free !== e.mean) begin
                  $error("mean_free exp %0d got %0d", e.mean, rsp_if.mean_free);
                  mismatches++;
               end
               if (rsp_if.spread !== e.dev) begin
                  $error("spread exp %0d got %0d", e.dev, rsp_if.spread);
                  mismatches++;
               end
               if (rsp_if.near_underrun_count !== e.under) begin
                  $error("near_underrun_count exp %0d got %0d", e.under,
                         rsp_if.near_underrun_count);
                  mismatches++;
               end
               if (rsp_if.near_block_count !== e.block) begin
                  $error("near_block_count exp %0d got %0d", e.block,
                         rsp_if.near_block_count);
                  mismatches++;
               end
               if (rsp_if.used_entries !== e.used) begin
                  $error("used_entries exp %0d got %0d", e.used, rsp_if.used_entries);
                  mismatches++;
               end
            end
         end
         window++;
         if (window >= 400) begin
            window = 0;
            case ($urandom_range(0, 2))
               0: stall_pct = 0;
               1: stall_pct = 15;
               default: stall_pct = 60;
            endcase
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 15);
         end
      end
   end

   // Watchdog on cycles without any accepted beat.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Sampled on the falling edge so that the driver's and monitor's updates have settled.
   task automatic wait_drained();
      while (pending_beats.size() != 0 || req_if.valid || expected_rsp.size() != 0)
         @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_BUFFER_SIZE: size_reg  = val[LEVEL_W-1:0];
         CSR_BASE_RATIO:  base_reg  = val;
         CSR_RATE_DELTA:  delta_reg = val[DELTA_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic push_beat(logic op, logic [LEVEL_W-1:0] level);
      level_beat_type b;
      b.op    = op;
      b.level = level;
      pending_beats.push_back(b);
   endtask

   function automatic logic [LEVEL_W-1:0] pick_level();
      longint unsigned sz;
      longint unsigned v;
      sz = size_reg;
      case ($urandom_range(0, 9))
         0: v = $urandom_range(0, 21'h1F_FFFF);
         1: v = 0;
         2: v = 21'h1F_FFFF;
         3: v = sz / 2;
         4: v = (sz * 3) / 4 + $urandom_range(0, 2) - 1;
         5: v = sz / 4 + $urandom_range(0, 2) - 1;
         default: v = $urandom_range(0, 32'(sz));
      endcase
      return v[LEVEL_W-1:0];
   endfunction

   // Mostly well-formed runs of measures closed by a report, some lone measure or report beats.
   task automatic queue_random(int count);
      int made;
      int run;
      made = 0;
      while (made < count) begin
         if ($urandom_range(0, 9) < 8) begin
            run = $urandom_range(1, 40);
            for (int k = 0; k < run; k++) push_beat(OP_MEASURE, pick_level());
            push_beat(OP_REPORT, LEVEL_W'($urandom_range(0, 21'h1F_FFFF)));
            made += run + 1;
         end else begin
            push_beat(1'($urandom_range(0, 1)), pick_level());
            made++;
         end
      end
   endtask

   initial begin
      reset       = 1'b1;
      csr_we      = 1'b0;
      csr_index   = CSR_BUFFER_SIZE;
      csr_wdata   = '0;
      drain_hold  = 1'b0;
      size_reg    = RST_BUFFER_SIZE;
      base_reg    = RST_BASE_RATIO;
      delta_reg   = RST_RATE_DELTA;
      meas_total  = 0;
      for (int i = 0; i < HIST; i++) level_hist[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty and short histories, level extremes, then a valid report.
      push_beat(OP_REPORT, 21'h1F_FFFF);
      push_beat(OP_MEASURE, 21'd0);
      push_beat(OP_REPORT, 21'd0);
      push_beat(OP_MEASURE, 21'h1F_FFFF);
      push_beat(OP_REPORT, 21'd5);
      push_beat(OP_MEASURE, 21'd2048);
      push_beat(OP_REPORT, 21'd0);
      push_beat(OP_MEASURE, 21'd3072);
      push_beat(OP_MEASURE, 21'd1024);
      push_beat(OP_MEASURE, 21'd1048576);
      push_beat(OP_MEASURE, 21'd3071);
      push_beat(OP_MEASURE, 21'd1025);
      push_beat(OP_REPORT, 21'h15_5555);
      push_beat(OP_MEASURE, 21'h0A_AAAA);
      push_beat(OP_REPORT, 21'd0);
      queue_random(300);

      // Hold the sender once until every beat sent so far has come back.
      while (pending_beats.size() > 150) @(posedge clock);
      drain_hold = 1'b1;
      @(negedge clock);
      while (req_if.valid || expected_rsp.size() != 0) @(negedge clock);
      drain_hold = 1'b0;
      wait_drained();

      write_reg(CSR_RATE_DELTA, 32'd65535);
      queue_random(300);
      wait_drained();

      // Bits above the register width must be ignored.
      write_reg(CSR_BUFFER_SIZE, 32'hFFE0_0002);
      write_reg(CSR_BASE_RATIO, 32'hFFFF_FFFF);
      queue_random(300);
      wait_drained();

      write_reg(CSR_BUFFER_SIZE, 32'd1048576);
      write_reg(CSR_BASE_RATIO, 32'd0);
      write_reg(CSR_RATE_DELTA, 32'd0);
      queue_random(300);
      wait_drained();

      write_reg(CSR_BUFFER_SIZE, $urandom_range(2, 1048576));
      write_reg(CSR_BASE_RATIO, $urandom);
      write_reg(CSR_RATE_DELTA, $urandom_range(0, 65535));
      queue_random(350);
      wait_drained();

      write_reg(CSR_BUFFER_SIZE, 32'd3);
      write_reg(CSR_BASE_RATIO, 32'h0003_0000);
      write_reg(CSR_RATE_DELTA, 32'd1);
      queue_random(380);
      wait_drained();
      repeat (300) @(posedge clock);

      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/afrc_pkg.sv
hw/rtl/afrc_if.sv
hw/rtl/afrc_ram.sv
hw/rtl/afrc_div.sv
hw/rtl/afrc_sqrt.sv
hw/rtl/afrc_ctrl.sv
hw/rtl/afrc_dp.sv
hw/rtl/audio_fifo_rate_control_monitor_top.sv
hw/rtl/afrc_chk.sv
tb/sv/tb_audio_fifo_rate_control_monitor_top.sv
